[sv/ir_carrier_spi_modulator_assert.svh]
// ---------------------------------------------------------------------------
// IR carrier SPI modulator assertion macros
// Concurrent property wrappers clocked on clk with synchronous reset rst_n.
// ---------------------------------------------------------------------------
`ifndef IR_CARRIER_SPI_MODULATOR_ASSERT_SVH
`define IR_CARRIER_SPI_MODULATOR_ASSERT_SVH

// Same-cycle implication.
`define IRCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define IRCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/ircs_pkg.sv]
// ---------------------------------------------------------------------------
// IR carrier SPI modulator package
// Shared constants, register indexes and controller/datapath structs.
// ---------------------------------------------------------------------------
package ircs_pkg;

  localparam int SLOTS_PER_FRAME     = 9;
  localparam int MAX_SAMPLES_PER_BIT = 63;
  localparam int SPB_W               = 6;
  localparam int BITS_PER_BYTE       = 8;
  localparam int CFG_IDX_W           = 1;
  localparam int CFG_DATA_W          = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD     = 1'd1;

  localparam logic [7:0]  CARRIER_PERIOD_RST = 8'd26;
  localparam logic [15:0] BIT_PERIOD_RST     = 16'd560;

  typedef struct packed {
    logic accept;
    logic spb_sat;
    logic div_init;
    logic div_step;
    logic div_finish;
    logic slot_step;
    logic flush;
    logic fin;
  } ircs_cmd_t;

  typedef struct packed {
    logic active;
    logic sat;
    logic div_last;
    logic run_end;
    logic last;
    logic flush_done;
    logic fin_done;
    logic pend_valid;
  } ircs_status_t;

endpackage

[sv/ircs_if.sv]
// ---------------------------------------------------------------------------
// IR carrier SPI modulator channels
// Valid/ready channels for command requests, result bytes and config.
// ---------------------------------------------------------------------------
interface ircs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_byte;
  logic       last_byte;
  modport source (output valid, output cmd_byte, output last_byte, input ready);
  modport sink   (input valid, input cmd_byte, input last_byte, output ready);
endinterface

interface ircs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface ircs_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/ir_carrier_spi_modulator.sv]
// ---------------------------------------------------------------------------
// IR carrier SPI modulator
// Expands command bytes into packed carrier samples for an SPI link.
// ---------------------------------------------------------------------------
//  channel  dir  payload                         handshake
//  in_ch    in   cmd_byte[7:0], last_byte        valid/ready
//  out_ch   out  out_byte[7:0], last_of_run      valid/ready
//  cfg_ch   in   index[0:0], data[15:0]          valid/ready (ready tied high)
//
// A request steps one sample slot per cycle through the slot sequencer while it is
// not held (none when samples_per_bit is zero); a last request adds a flush step.
// The first request of a command runs the restoring divider before its slots
// (one quotient bit per cycle), which is skipped when the result saturates.
// Reset is synchronous on rst_n; no clearing pass is needed.
// A full output register that is not taken and a full pending byte hold the slot sequencer and the flush.
// ---------------------------------------------------------------------------
`include "ir_carrier_spi_modulator_assert.svh"

module ir_carrier_spi_modulator (
  input  logic        clk,
  input  logic        rst_n,
  ircs_in_if.sink     in_ch,
  ircs_out_if.source  out_ch,
  ircs_cfg_if.sink    cfg_ch
);
  import ircs_pkg::*;

  ircs_cmd_t    cmd;
  ircs_status_t st;
  logic         cfg_we;

  // Config writes are always taken; the user must land them between commands, as the block does not enforce it.
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  // Sequencer: command start, divider, slot loop, flush, hand-off.
  ircs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: registers, divider, packer and result buffer.
  ircs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_ch.index),
    .cfg_wdata    (cfg_ch.data),
    .in_cmd_byte  (in_ch.cmd_byte),
    .in_last_byte (in_ch.last_byte),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_byte     (out_ch.out_byte),
    .out_last     (out_ch.last_of_run)
  );

  // Drop ready after every accepted request until its work is done.
  `IRCS_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "not busy")
  // Never take a new request while a byte is still parked in the pending slot.
  `IRCS_ASSERT_NOW(a_idle_no_pending, in_ch.ready, !st.pend_valid, "pending byte left at idle")
  // A waiting non-final byte means its request is still in progress.
  `IRCS_ASSERT_NOW(a_run_closed, out_ch.valid && !out_ch.last_of_run, !in_ch.ready, "run open")

endmodule

[sv/ircs_ctrl.sv]
// ---------------------------------------------------------------------------
// IR carrier SPI modulator controller
// Sequences command start, division, slot expansion, flush and hand-off.
// ---------------------------------------------------------------------------
module ircs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ircs_pkg::ircs_status_t st,
  output ircs_pkg::ircs_cmd_t    cmd
);
  import ircs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_DIV, S_DIVEND, S_RUN, S_FLUSH, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.accept   = 1'b1;
          state_nxt    = S_START;
          in_ready_nxt = 1'b0;
        end
      end
      S_START: begin
        if (st.active) begin
          state_nxt = S_RUN;
        end else if (st.sat) begin
          cmd.spb_sat = 1'b1;
          state_nxt   = S_RUN;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = S_DIVEND;
      end
      S_DIVEND: begin
        cmd.div_finish = 1'b1;
        state_nxt      = S_RUN;
      end
      S_RUN: begin
        cmd.slot_step = 1'b1;
        if (st.run_end) state_nxt = st.last ? S_FLUSH : S_FIN;
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        if (st.flush_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (st.fin_done) begin
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

[sv/ircs_dp.sv]
// ---------------------------------------------------------------------------
// IR carrier SPI modulator datapath
// Config registers, slot divider, sample packer and two-entry result buffer.
// ---------------------------------------------------------------------------
module ircs_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ircs_pkg::ircs_cmd_t    cmd,
  output ircs_pkg::ircs_status_t st,
  input  logic                  cfg_we,
  input  logic [ircs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ircs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [7:0]            in_cmd_byte,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_last
);
  import ircs_pkg::*;

  logic [7:0]       cp_r;
  logic [15:0]      bp_r;
  logic [16:0]      rem_r;
  logic [SPB_W-1:0] quo_r;
  logic [2:0]       k_r;
  logic [SPB_W-1:0] spb_r;
  logic             active_r;
  logic [7:0]       data_r;
  logic             last_r;
  logic [2:0]       bit_cnt_r;
  logic [SPB_W-1:0] t_cnt_r;
  logic             odd_r;
  logic [3:0]       slot_pos_r;
  logic [7:0]       partial_r;
  logic             pend_valid_r;
  logic [7:0]       pend_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic [16:0] twice;
  logic [13:0] sat_lim;
  logic        sat;
  logic [16:0] trial;
  logic        fits;
  logic        in_stop;
  logic        samp;
  logic [7:0]  new_byte;
  logic        byte_full;
  logic        can_push;
  logic        slot_stall;
  logic        bit_end;
  logic        flush_need;
  logic        flush_stall;
  logic        step_go;
  logic        flush_go;
  logic        push;
  logic [7:0]  push_data;

  assign twice   = {bp_r, 1'b0};
  assign sat_lim = {6'd0, cp_r} * 14'(MAX_SAMPLES_PER_BIT);
  assign sat     = (cp_r == 8'd0) || (twice > {3'd0, sat_lim});
  assign trial   = {4'd0, 13'({5'd0, cp_r} << k_r)};
  assign fits    = rem_r >= trial;

  assign in_stop    = (slot_pos_r == 4'(SLOTS_PER_FRAME - 1));
  assign samp       = data_r[7] & ~odd_r;
  assign new_byte   = partial_r | (8'({7'd0, samp}) << (3'd7 - slot_pos_r[2:0]));
  assign byte_full  = !in_stop && (slot_pos_r[2:0] == 3'd7);
  assign can_push   = !pend_valid_r || !out_valid_r || out_ready;
  assign slot_stall = byte_full && !can_push;
  assign bit_end    = (t_cnt_r == spb_r - 6'd1);
  assign step_go    = cmd.slot_step && (spb_r != '0) && !slot_stall;

  assign flush_need  = (slot_pos_r != 4'd0) && !slot_pos_r[3];
  assign flush_stall = flush_need && !can_push;
  assign flush_go    = cmd.flush && !flush_stall;

  assign push      = (step_go && byte_full) || (flush_go && flush_need);
  assign push_data = flush_go ? partial_r : new_byte;

  always_comb begin
    st            = '0;
    st.active     = active_r;
    st.sat        = sat;
    st.div_last   = (k_r == 3'd0);
    st.run_end    = (spb_r == '0) || ((bit_cnt_r == 3'd7) && bit_end && !slot_stall);
    st.last       = last_r;
    st.flush_done = !flush_stall;
    st.fin_done   = can_push;
    st.pend_valid = pend_valid_r;
  end

  // Config registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r <= CARRIER_PERIOD_RST;
      bp_r <= BIT_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CARRIER_PERIOD: cp_r <= cfg_wdata[7:0];
        REG_BIT_PERIOD:     bp_r <= cfg_wdata;
        default:            ;
      endcase
    end
  end

  // Restoring divider, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= twice;
      quo_r <= '0;
      k_r   <= 3'd5;
    end else if (cmd.div_step) begin
      if (fits) begin
        rem_r     <= rem_r - trial;
        quo_r[k_r] <= 1'b1;
      end
      k_r <= k_r - 3'd1;
    end
  end

  // Command, slot and packing state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_r      <= '0;
      active_r   <= 1'b0;
      slot_pos_r <= '0;
      partial_r  <= '0;
      bit_cnt_r  <= '0;
      t_cnt_r    <= '0;
      odd_r      <= 1'b0;
      last_r     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        data_r    <= in_cmd_byte;
        last_r    <= in_last_byte;
        bit_cnt_r <= '0;
        t_cnt_r   <= '0;
        odd_r     <= 1'b0;
      end
      if (cmd.spb_sat) begin
        spb_r    <= SPB_W'(MAX_SAMPLES_PER_BIT);
        active_r <= 1'b1;
      end
      if (cmd.div_finish) begin
        spb_r    <= quo_r + SPB_W'(rem_r != 17'd0);
        active_r <= 1'b1;
      end
      if (step_go) begin
        if (in_stop) begin
          slot_pos_r <= '0;
        end else begin
          partial_r  <= byte_full ? 8'd0 : new_byte;
          slot_pos_r <= slot_pos_r + 4'd1;
        end
        if (bit_end) begin
          t_cnt_r   <= '0;
          odd_r     <= 1'b0;
          data_r    <= {data_r[6:0], 1'b0};
          bit_cnt_r <= bit_cnt_r + 3'd1;
        end else begin
          t_cnt_r <= t_cnt_r + 6'd1;
          if (!in_stop) odd_r <= ~odd_r;
        end
      end
      if (flush_go) begin
        slot_pos_r <= '0;
        partial_r  <= '0;
        active_r   <= 1'b0;
      end
    end
  end

  // Pending byte plus output register: the pending byte is marked last
  // only once the request is known to produce nothing more.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (push) begin
        if (pend_valid_r) begin
          out_valid_r <= 1'b1;
          out_byte_r  <= pend_r;
          out_last_r  <= 1'b0;
        end else if (out_ready) begin
          out_valid_r <= 1'b0;
        end
        pend_valid_r <= 1'b1;
        pend_r       <= push_data;
      end else if (cmd.fin && pend_valid_r && can_push) begin
        out_valid_r  <= 1'b1;
        out_byte_r   <= pend_r;
        out_last_r   <= 1'b1;
        pend_valid_r <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule
